// File: hw/rtl/srtt_pkg.sv
// ---------------------------------------------------------------------------
// srtt_pkg: shared types and constants of the retransmit timer table
// Holds the field widths, command and result codes, configuration register
// indexes and reset values, and the control/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package srtt_pkg;

    // Field widths of the stream and configuration ports.
    localparam int OP_W       = 2;
    localparam int SESS_W     = 10;
    localparam int KIND_W     = 4;
    localparam int RETRY_W    = 3;
    localparam int RKIND_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int M_USED_W   = SESS_W + KIND_W + RETRY_W;

    // Item operations carried on s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_RX_LOAD = 2'd0,
        OP_RX_STOP = 2'd1,
        OP_TX_SET  = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Result kinds carried on m_tuser.
    typedef enum logic [RKIND_W-1:0] {
        RK_TIMEOUT  = 2'd0,
        RK_ABORT_TX = 2'd1,
        RK_ABORT_RX = 2'd2
    } rkind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD  = 3'd0,
        CFG_FIRST   = 3'd1,
        CFG_SECOND  = 3'd2,
        CFG_THIRD   = 3'd3,
        CFG_FINAL   = 3'd4,
        CFG_LIMIT   = 3'd5,
        CFG_SYN     = 3'd6
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] RELOAD_RST = 32'd152588;
    localparam logic [CFG_DATA_W-1:0] FIRST_RST  = 32'd457764;
    localparam logic [CFG_DATA_W-1:0] SECOND_RST = 32'd915527;
    localparam logic [CFG_DATA_W-1:0] THIRD_RST  = 32'd1831055;
    localparam logic [CFG_DATA_W-1:0] FINAL_RST  = 32'd4577637;
    localparam logic [RETRY_W-1:0]    LIMIT_RST  = 3'd4;
    localparam logic [KIND_W-1:0]     SYN_RST    = 4'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the clearing pointer
        logic item_load;  // capture the item and read its table entry
        logic commit;     // write the entry back and emit any result
    } srtt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last; // clearing pointer is at the last entry
        logic stall;      // result pending but the output register is held
    } srtt_sts_t;

endpackage

// File: hw/rtl/srtt_ctrl.sv
// ---------------------------------------------------------------------------
// srtt_ctrl: sequencing controller of the retransmit timer table
// Runs the clearing pass after reset, then alternates between accepting an
// item (table read) and executing it (update, write-back, result).
// ---------------------------------------------------------------------------
module srtt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  srtt_pkg::srtt_sts_t sts,
    output srtt_pkg::srtt_cmd_t cmd
);
    import srtt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cmd.clear_wr  = 1'b0;
        cmd.item_load = 1'b0;
        cmd.commit    = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold the entry while a new result cannot be registered.
                if (!sts.stall) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/srtt_datapath.sv
// ---------------------------------------------------------------------------
// srtt_datapath: timer table, configuration registers and update logic
// Holds the per-session table memory, the scan and clearing pointers, the
// entry update for each operation and the registered result output.
// ---------------------------------------------------------------------------
module srtt_datapath #(
    parameter int SESSIONS   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  srtt_pkg::srtt_cmd_t                cmd,
    output srtt_pkg::srtt_sts_t                sts,
    input  logic [srtt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [srtt_pkg::OP_W-1:0]          s_tuser,
    input  logic                               cfg_valid,
    input  logic [srtt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srtt_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [srtt_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [srtt_pkg::RKIND_W-1:0]       m_tuser
);
    import srtt_pkg::*;

    localparam int ADDR_BITS = $clog2(SESSIONS);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(SESSIONS - 1);

    typedef struct packed {
        logic [KIND_W-1:0]     ev_type;
        logic [RETRY_W-1:0]    retries;
        logic                  active;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // Timer table memory.
    entry_t mem [SESSIONS];

    // Configuration registers.
    logic [CFG_DATA_W-1:0] reload_reg;
    logic [CFG_DATA_W-1:0] first_reg;
    logic [CFG_DATA_W-1:0] second_reg;
    logic [CFG_DATA_W-1:0] third_reg;
    logic [CFG_DATA_W-1:0] final_reg;
    logic [RETRY_W-1:0]    limit_reg;
    logic [KIND_W-1:0]     syn_reg;

    // Item and pointer registers.
    op_t                   op_reg;
    logic                  sess_ok_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [ADDR_BITS-1:0]  scan_reg;
    logic [ADDR_BITS-1:0]  scan_next;
    logic [ADDR_BITS-1:0]  clr_reg;
    entry_t                rd_reg;

    // Output register.
    logic                  m_valid_reg;
    rkind_t                out_kind_reg;
    logic [SESS_W-1:0]     out_sess_reg;
    logic [KIND_W-1:0]     out_type_reg;
    logic [RETRY_W-1:0]    out_retry_reg;

    // Item decode.
    op_t                   in_op;
    logic [SESS_W-1:0]     in_sess;
    logic [KIND_W-1:0]     in_kind;
    logic                  in_ok;
    logic [ADDR_BITS-1:0]  rd_addr;

    // Update logic.
    entry_t                upd;
    logic [COUNT_BITS-1:0] start_cnt;
    logic                  res_valid;
    rkind_t                res_kind;
    logic [RETRY_W-1:0]    res_retry;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    entry_t                wr_data;

    assign in_op   = op_t'(s_tuser);
    assign in_sess = s_tdata[SESS_W-1:0];
    assign in_kind = s_tdata[SESS_W+KIND_W-1:SESS_W];
    assign in_ok   = (32'(in_sess) < SESSIONS);

    // A tick reads at the scan pointer, a command at its session.
    always_comb begin
        priority if (in_op == OP_TICK) begin
            rd_addr = scan_reg;
        end else if (in_ok) begin
            rd_addr = ADDR_BITS'(in_sess);
        end else begin
            rd_addr = '0;
        end
    end

    assign scan_next = (scan_reg == LAST_ADDR) ? '0 : scan_reg + 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= RELOAD_RST;
            first_reg  <= FIRST_RST;
            second_reg <= SECOND_RST;
            third_reg  <= THIRD_RST;
            final_reg  <= FINAL_RST;
            limit_reg  <= LIMIT_RST;
            syn_reg    <= SYN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RELOAD: reload_reg <= cfg_data;
                CFG_FIRST:  first_reg  <= cfg_data;
                CFG_SECOND: second_reg <= cfg_data;
                CFG_THIRD:  third_reg  <= cfg_data;
                CFG_FINAL:  final_reg  <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[RETRY_W-1:0];
                CFG_SYN:    syn_reg    <= cfg_data[KIND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scan and clearing pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
            clr_reg  <= '0;
        end else begin
            if (cmd.item_load && (in_op == OP_TICK)) begin
                scan_reg <= scan_next;
            end
            if (cmd.clear_wr && (clr_reg != LAST_ADDR)) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign sts.clear_last = (clr_reg == LAST_ADDR);

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            op_reg      <= in_op;
            sess_ok_reg <= in_ok;
            addr_reg    <= rd_addr;
            kind_reg    <= in_kind;
        end
    end

    // Start count selected by the retry count.
    always_comb begin
        unique case (rd_reg.retries)
            3'd0:    start_cnt = COUNT_BITS'(first_reg);
            3'd1:    start_cnt = COUNT_BITS'(second_reg);
            3'd2:    start_cnt = COUNT_BITS'(third_reg);
            default: start_cnt = COUNT_BITS'(final_reg);
        endcase
    end

    // Entry update and result.
    always_comb begin
        upd       = rd_reg;
        res_valid = 1'b0;
        res_kind  = RK_TIMEOUT;
        res_retry = '0;
        unique case (op_reg)
            OP_RX_LOAD: begin
                upd.count   = COUNT_BITS'(reload_reg);
                upd.retries = '0;
            end
            OP_RX_STOP: begin
                upd.count   = '0;
                upd.active  = 1'b0;
                upd.retries = '0;
            end
            OP_TX_SET: begin
                upd.ev_type = kind_reg;
                if (!rd_reg.active) begin
                    upd.count  = start_cnt;
                    upd.active = 1'b1;
                end
            end
            OP_TICK: begin
                if (rd_reg.active) begin
                    if (rd_reg.count != '0) begin
                        upd.count = rd_reg.count - 1'b1;
                    end else begin
                        // Expiry: either a timeout event or an abort.
                        upd.active = 1'b0;
                        res_valid  = 1'b1;
                        if (rd_reg.retries < limit_reg) begin
                            upd.retries = rd_reg.retries + 1'b1;
                            res_retry   = rd_reg.retries + 1'b1;
                        end else begin
                            upd.retries = '0;
                            res_kind    = (rd_reg.ev_type == syn_reg) ? RK_ABORT_TX
                                                                      : RK_ABORT_RX;
                        end
                    end
                end
            end
        endcase
    end

    assign sts.stall = res_valid && m_valid_reg && !m_tready;

    // Table write port: clearing pass or write-back.
    assign wr_en   = cmd.clear_wr || (cmd.commit && ((op_reg == OP_TICK) || sess_ok_reg));
    assign wr_addr = cmd.clear_wr ? clr_reg : addr_reg;
    assign wr_data = cmd.clear_wr ? entry_t'('0) : upd;

    // Table memory with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.item_load) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (cmd.commit && res_valid) begin
            out_kind_reg  <= res_kind;
            out_sess_reg  <= SESS_W'(addr_reg);
            out_type_reg  <= rd_reg.ev_type;
            out_retry_reg <= res_retry;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, out_retry_reg, out_type_reg, out_sess_reg};

endmodule

// File: hw/rtl/session_retransmit_timer_table.sv
// ---------------------------------------------------------------------------
// session_retransmit_timer_table: per-session retransmit timer table
// Keeps one retransmit timer per session and reports timeouts and aborts.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries RX load, RX stop, TX set and scan tick items; the
//   operation travels on s_tuser. A scan tick visits one session at a
//   wrapping scan pointer and may produce one result on the m_ channel, a
//   timeout event or an abort, with its kind on m_tuser. RX and TX commands
//   never produce a result. Configuration registers are written on the cfg_
//   channel, which is always ready; write them only while no item is in work.
//   Each item is handled in a read step, which reads its table entry from the
//   table memory, and an update step, which updates it and writes it back. A
//   result passes through the table read register and the output register to m_tvalid.
//   After reset the table is cleared one entry per cycle, all entries in turn,
//   while s_tready stays low. The result sits in an output register, so the
//   next item is taken while it waits; a tick that produces a new result
//   while the receiver still stalls the previous one waits in the table
//   update step until the output register frees up.
// ---------------------------------------------------------------------------
module session_retransmit_timer_table #(
    parameter int SESSIONS   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srtt_pkg::S_TDATA_W-1:0]  s_tdata,  // session[9:0], event_kind[13:10], zeros
    input  logic [srtt_pkg::OP_W-1:0]       s_tuser,  // op[1:0]
    // Results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srtt_pkg::M_TDATA_W-1:0]  m_tdata,  // target_session[9:0],
                                                      // timeout_type[13:10],
                                                      // retry_count[16:14], zeros
    output logic [srtt_pkg::RKIND_W-1:0]    m_tuser,  // result_kind[1:0]
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srtt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srtt_pkg::*;

    srtt_cmd_t cmd;
    srtt_sts_t sts;

    // Configuration registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    // Controller.
    srtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    srtt_datapath #(
        .SESSIONS   (SESSIONS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hw/rtl/srtt_checker.sv
// ---------------------------------------------------------------------------
// srtt_checker: port-level checks of the retransmit timer table
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module srtt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srtt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [srtt_pkg::RKIND_W-1:0]    m_tuser
);
    import srtt_pkg::*;

    // The table clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // One item is worked on at a time: no accept in the cycle after an accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // A timeout event reports a nonzero retry count, an abort reports zero.
    a_retry_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == RK_TIMEOUT) == (m_tdata[16:14] != 3'd0)))
        else $error("retry count does not match the result kind");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind session_retransmit_timer_table srtt_checker u_srtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/session_retransmit_timer_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// session_retransmit_timer_table_tb: self-checking bench for the timer table
// Drives RX load, RX stop, TX set and scan tick transfers into the block and
// predicts every timeout and abort with its own copy of the timer table. A
// short directed table comes first. Random traffic follows under three
// timer settings and three handshake patterns. Every result transfer is
// checked field by field against the oldest pending prediction.
// ---------------------------------------------------------------------------
module session_retransmit_timer_table_tb;
    import srtt_pkg::*;

    localparam int SESSIONS      = 1024;
    localparam int SETTLE_CYCLES = 8;        // item pipeline depth plus margin
    localparam int CYCLE_LIMIT   = 1000000;  // far above the slowest legal run
    localparam int PLAN_ROWS     = 30;

    // One timer entry, and one timeout or abort as seen on the result port.
    typedef struct packed {
        logic [31:0] count;
        logic        active;
        logic [2:0]  retries;
        logic [3:0]  ttype;
    } timer_t;

    typedef struct packed {
        rkind_t      kind;
        logic [9:0]  sess;
        logic [3:0]  ttype;
        logic [2:0]  retry;
    } expiry_t;

    // Directed table: register writes and items, with an optional typed result.
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        GIVEN
    } check_t;

    typedef struct packed {
        logic        is_cfg;
        cfg_idx_t    idx;
        logic [31:0] val;
        op_t         op;
        logic [9:0]  sess;
        logic [3:0]  kind;
        check_t      how;
        expiry_t     want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [RKIND_W-1:0]    m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted timer state and configuration.
    timer_t      timers [SESSIONS];
    logic [9:0]  scan_idx;
    logic [31:0] reload_q;
    logic [31:0] start_ticks [4];
    logic [2:0]  limit_q;
    logic [3:0]  syn_q;
    expiry_t     pending_q [$];

    plan_row_t   plan [PLAN_ROWS];
    int          tx_gap_pct;
    int          rx_stall_pct;
    int          n_cycles;
    int          n_faults;
    int          n_items;
    int          n_ticks;
    int          n_results;
    int          n_timeouts;
    int          n_abort_tx;
    int          n_abort_rx;

    session_retransmit_timer_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Put the predictor in its post-reset state.
    function automatic void reset_timers();
        for (int i = 0; i < SESSIONS; i++) timers[i] = '0;
        scan_idx       = '0;
        reload_q       = RELOAD_RST;
        start_ticks[0] = FIRST_RST;
        start_ticks[1] = SECOND_RST;
        start_ticks[2] = THIRD_RST;
        start_ticks[3] = FINAL_RST;
        limit_q        = LIMIT_RST;
        syn_q          = SYN_RST;
    endfunction

    // Apply one accepted item to the predicted table; returns 1 when it expires
    // an entry, with the timeout or abort in res.
    function automatic bit step_timers(input op_t op, input logic [9:0] sess,
                                       input logic [3:0] kind, output expiry_t res);
        timer_t     t;
        logic [9:0] at;
        res = '0;
        if (op != OP_TICK) begin
            t = timers[sess];
            case (op)
                OP_RX_LOAD: begin
                    t.count   = reload_q;
                    t.retries = '0;
                end
                OP_RX_STOP: begin
                    t.count   = '0;
                    t.active  = 1'b0;
                    t.retries = '0;
                end
                OP_TX_SET: begin
                    t.ttype = kind;
                    // An idle timer starts with the timeout its retries select.
                    if (!t.active) begin
                        t.count  = start_ticks[(t.retries > 3'd3) ? 3 : t.retries];
                        t.active = 1'b1;
                    end
                end
                default: ;
            endcase
            timers[sess] = t;
            return 1'b0;
        end

        at       = scan_idx;
        scan_idx = (at == 10'(SESSIONS - 1)) ? '0 : at + 10'd1;
        t        = timers[at];
        if (!t.active)
            return 1'b0;
        if (t.count != '0) begin
            t.count    = t.count - 32'd1;
            timers[at] = t;
            return 1'b0;
        end

        // Count already at zero: the entry expires on this visit.
        t.active  = 1'b0;
        res.sess  = at;
        res.ttype = t.ttype;
        if (t.retries < limit_q) begin
            t.retries = t.retries + 3'd1;
            res.kind  = RK_TIMEOUT;
            res.retry = t.retries;
            n_timeouts++;
        end else begin
            t.retries = '0;
            res.kind  = (t.ttype == syn_q) ? RK_ABORT_TX : RK_ABORT_RX;
            res.retry = '0;
            if (res.kind == RK_ABORT_TX) n_abort_tx++;
            else n_abort_rx++;
        end
        timers[at] = t;
        n_results++;
        return 1'b1;
    endfunction

    function automatic void log_fault(input string msg);
        n_faults++;
        if (n_faults <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    // Directed table row builders.
    function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [31:0] val);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(input op_t op, input logic [9:0] sess,
                                          input logic [3:0] kind);
        plan_row_t r;
        r      = '0;
        r.op   = op;
        r.sess = sess;
        r.kind = kind;
        r.how  = BY_MODEL;
        return r;
    endfunction

    function automatic plan_row_t tick_row(input check_t how, input rkind_t rk,
                                           input logic [9:0] sess, input logic [3:0] ttype,
                                           input logic [2:0] retry);
        plan_row_t r;
        r             = '0;
        r.op          = OP_TICK;
        r.how         = how;
        r.want.kind   = rk;
        r.want.sess   = sess;
        r.want.ttype  = ttype;
        r.want.retry  = retry;
        return r;
    endfunction

    // Send one item, after a random gap that may be empty, and predict its effect once
    // the transfer is taken.
    task automatic send_item(input op_t op, input logic [9:0] sess, input logic [3:0] kind,
                             output bit got, output expiry_t res);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, kind, sess};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (op == OP_TICK) n_ticks++;
        got = step_timers(op, sess, kind, res);
    endtask

    // Hold the input side until every predicted result has arrived and the
    // last item has left the pipeline.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; cfg_valid is left high for a following write.
    task automatic put_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RELOAD: reload_q       = val;
            CFG_FIRST:  start_ticks[0] = val;
            CFG_SECOND: start_ticks[1] = val;
            CFG_THIRD:  start_ticks[2] = val;
            CFG_FINAL:  start_ticks[3] = val;
            CFG_LIMIT:  limit_q        = val[2:0];
            CFG_SYN:    syn_q          = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_timers(input logic [31:0] reload, input logic [31:0] first,
                              input logic [31:0] second, input logic [31:0] third,
                              input logic [31:0] last, input logic [31:0] limit,
                              input logic [31:0] syn);
        drain();
        put_reg(CFG_RELOAD, reload);
        put_reg(CFG_FIRST, first);
        put_reg(CFG_SECOND, second);
        put_reg(CFG_THIRD, third);
        put_reg(CFG_FINAL, last);
        put_reg(CFG_LIMIT, limit);
        put_reg(CFG_SYN, syn);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic concentrated just around the scan pointer, so that armed
    // timers are visited soon; a few items go anywhere. Every item counts
    // against the quota; a phase runs on a little when it has seen few results.
    task automatic run_phase(input int quota, input int gap_pct, input int stall_pct);
        int         counted;
        int         sent;
        int         first_res;
        int         pick;
        op_t        op;
        logic [9:0] sess;
        logic [3:0] kind;
        bit         got;
        expiry_t    res;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        counted      = 0;
        sent         = 0;
        first_res    = n_results;
        while ((counted < quota || n_results - first_res < 16) && sent < 8 * quota) begin
            pick = $urandom_range(0, 99);
            sess = scan_idx + 10'($urandom_range(0, 35)) - 10'd4;
            kind = ($urandom_range(0, 3) == 0) ? syn_q : 4'($urandom_range(0, 15));
            if (pick < 55) begin
                op   = OP_TICK;
                sess = 10'($urandom);
            end else if (pick < 80) begin
                op = OP_TX_SET;
            end else if (pick < 88) begin
                op = OP_RX_LOAD;
            end else if (pick < 94) begin
                op = OP_RX_STOP;
            end else begin
                op   = op_t'(2'($urandom_range(0, 3)));
                sess = 10'($urandom_range(0, SESSIONS - 1));
            end
            counted++;
            sent++;
            send_item(op, sess, kind, got, res);
            if (got) pending_q.push_back(res);
        end
    endtask

    // Receiver readiness.
    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // Result checker: each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        expiry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                log_fault($sformatf("unexpected result: kind %0d session %0d type %0d retry %0d",
                                    m_tuser, m_tdata[9:0], m_tdata[13:10], m_tdata[16:14]));
            end else begin
                want = pending_q.pop_front();
                if (m_tuser !== want.kind || m_tdata[9:0] !== want.sess ||
                    m_tdata[13:10] !== want.ttype || m_tdata[16:14] !== want.retry) begin
                    log_fault($sformatf({"result mismatch: expected kind %0d session %0d ",
                                         "type %0d retry %0d, got %0d %0d %0d %0d"},
                                        want.kind, want.sess, want.ttype, want.retry,
                                        m_tuser, m_tdata[9:0], m_tdata[13:10],
                                        m_tdata[16:14]));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("session_retransmit_timer_table: mismatch");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        bit      got;
        expiry_t res;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_RX_LOAD;
        m_tready     <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_RELOAD;
        cfg_data     <= '0;
        n_cycles     = 0;
        n_faults     = 0;
        n_items      = 0;
        n_ticks      = 0;
        n_results    = 0;
        n_timeouts   = 0;
        n_abort_tx   = 0;
        n_abort_rx   = 0;
        tx_gap_pct   = 19;
        rx_stall_pct = 83;
        reset_timers();

        // The scan pointer starts at zero; each tick below visits the next entry.
        plan = '{
            tick_row(NO_RESULT, RK_TIMEOUT, 10'd0, 4'd0, 3'd0),   // cleared entry
            cmd_row(OP_TX_SET, 10'd1023, 4'd15),                   // long reset timeout
            cmd_row(OP_RX_LOAD, 10'd0, 4'd0),
            reg_row(CFG_RELOAD, 32'd0),
            reg_row(CFG_FIRST, 32'd0),
            reg_row(CFG_SECOND, 32'd0),
            reg_row(CFG_THIRD, 32'd0),
            reg_row(CFG_FINAL, 32'd0),
            reg_row(CFG_LIMIT, 32'hFFFF_FFF8),                     // masks to zero
            reg_row(CFG_SYN, 32'hFFFF_FFFF),                       // masks to 15
            // A zero retry limit aborts on the first expiry.
            cmd_row(OP_TX_SET, 10'd1, 4'd15),
            tick_row(GIVEN, RK_ABORT_TX, 10'd1, 4'd15, 3'd0),
            cmd_row(OP_TX_SET, 10'd2, 4'd0),
            tick_row(GIVEN, RK_ABORT_RX, 10'd2, 4'd0, 3'd0),
            reg_row(CFG_LIMIT, 32'd7),
            cmd_row(OP_TX_SET, 10'd3, 4'd9),
            tick_row(GIVEN, RK_TIMEOUT, 10'd3, 4'd9, 3'd1),
            // A stopped timer stays quiet.
            cmd_row(OP_TX_SET, 10'd4, 4'd4),
            cmd_row(OP_RX_STOP, 10'd4, 4'd0),
            tick_row(NO_RESULT, RK_TIMEOUT, 10'd0, 4'd0, 3'd0),
            // Reload keeps the timer running; a second TX set only retypes it.
            cmd_row(OP_TX_SET, 10'd5, 4'd2),
            cmd_row(OP_RX_LOAD, 10'd5, 4'd0),
            cmd_row(OP_TX_SET, 10'd5, 4'd7),
            tick_row(GIVEN, RK_TIMEOUT, 10'd5, 4'd7, 3'd1),
            // A reload on an idle timer does not start it.
            cmd_row(OP_RX_LOAD, 10'd6, 4'd0),
            tick_row(NO_RESULT, RK_TIMEOUT, 10'd0, 4'd0, 3'd0),
            // A count of one only counts down on this pass.
            reg_row(CFG_FIRST, 32'd1),
            cmd_row(OP_TX_SET, 10'd7, 4'd10),
            tick_row(NO_RESULT, RK_TIMEOUT, 10'd0, 4'd0, 3'd0),
            cmd_row(OP_TX_SET, 10'd3, 4'd9)                        // second timeout
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part; register writes wait for the block to go idle.
        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].is_cfg) begin
                if (i == 0 || !plan[i - 1].is_cfg) drain();
                put_reg(plan[i].idx, plan[i].val);
            end else begin
                if (i > 0 && plan[i - 1].is_cfg) cfg_valid <= 1'b0;
                send_item(plan[i].op, plan[i].sess, plan[i].kind, got, res);
                if (plan[i].how == GIVEN) pending_q.push_back(plan[i].want);
                else if (plan[i].how == BY_MODEL && got) pending_q.push_back(res);
            end
        end

        // Random part under three settings and three handshake patterns.
        set_timers(32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd3, 32'd0);
        run_phase(476, 19, 83);
        set_timers(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0,
                   32'($urandom_range(0, 15)));
        run_phase(476, 83, 19);
        set_timers(32'd0, 32'($urandom_range(0, 1)), 32'd0, 32'd2, 32'd0, 32'd1, $urandom);
        run_phase(477, 0, 0);
        drain();

        $display("Run covered %0d items, %0d of them scan ticks (%0d full passes).",
                 n_items, n_ticks, n_ticks / SESSIONS);
        $display("Predicted %0d timeouts, %0d aborts to TX and %0d aborts to RX.",
                 n_timeouts, n_abort_tx, n_abort_rx);
        if (n_faults == 0 && pending_q.size() == 0) begin
            $display("session_retransmit_timer_table: match");
        end else begin
            $display("session_retransmit_timer_table: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/srtt_pkg.sv
hw/rtl/srtt_ctrl.sv
hw/rtl/srtt_datapath.sv
hw/rtl/session_retransmit_timer_table.sv
hw/rtl/srtt_checker.sv
dv/session_retransmit_timer_table_tb.sv
